// ===== design/pbsr_pkg.sv =====
`default_nettype none

package pbsr_pkg;

    // Field widths of the item channels
    localparam int OP_W        = 1;
    localparam int SLOT_W      = 7;
    localparam int POSX_IN_W   = 14;
    localparam int POSY_IN_W   = 13;
    localparam int VEL_W       = 12;
    localparam int ROW_NUM_W   = 5;
    localparam int ROW_CELLS_W = 64;

    // Stored position width: covers a loaded x and any grid up to 64 cells
    localparam int POS_W  = 14;
    localparam int CELL_W = 6;
    localparam int SUM_W  = 16;
    localparam int PROD_W = 21;
    localparam int MAG_W  = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int GRAV_W     = 8;
    localparam int DAMP_W     = 9;
    localparam int MARGIN_W   = 11;
    localparam int COUNT_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_DAMPING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_MARGIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 2'd3;

    localparam logic [GRAV_W-1:0]   GRAVITY_RESET = 8'd38;
    localparam logic [DAMP_W-1:0]   DAMPING_RESET = 9'd210;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET  = 11'd512;
    localparam logic [COUNT_W-1:0]  COUNT_RESET   = 8'd100;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic signed [VEL_W-1:0] VEL_MAX   = 12'sh7FF;
    localparam logic signed [VEL_W-1:0] VEL_MIN   = 12'sh800;
    localparam logic signed [VEL_W:0]   VEL_MAX_W = 13'sd2047;
    localparam logic [MAG_W-1:0]        POS_MAG_MAX = 13'd2047;
    localparam logic [MAG_W-1:0]        NEG_MAG_MAX = 13'd2048;
    localparam logic signed [SUM_W-1:0] INSET_LSB = 16'sd26;

    localparam int MAX_PARTICLES_DEF = 128;
    localparam int GRID_WIDTH_DEF    = 64;
    localparam int GRID_HEIGHT_DEF   = 32;

    typedef struct packed {
        logic                    op;
        logic [SLOT_W-1:0]       slot;
        logic [POSX_IN_W-1:0]    pos_x;
        logic [POSY_IN_W-1:0]    pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
    } cmd_item_t;

    typedef struct packed {
        logic [ROW_NUM_W-1:0]   row_number;
        logic [ROW_CELLS_W-1:0] row_cells;
        logic                   final_row;
    } row_item_t;

    typedef struct packed {
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
    } particle_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_STAGE_A,
        ST_STAGE_B,
        ST_WRITE,
        ST_PLOT,
        ST_EMIT_READ,
        ST_EMIT_LOAD,
        ST_EMIT_WAIT
    } pbsr_state_t;

    typedef struct packed {
        logic load_wr;
        logic clr_wr;
        logic row_zero;
        logic row_inc;
        logic idx_zero;
        logic idx_inc;
        logic store_rd;
        logic rd_next;
        logic a_en;
        logic b_en;
        logic wb_en;
        logic plot_wr;
        logic emit_rd;
        logic emit_next;
        logic out_load;
    } pbsr_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic idx_last;
        logic row_last;
    } pbsr_stat_t;

endpackage

`default_nettype wire

// ===== design/pbsr_axis.sv =====
`default_nettype none

module pbsr_axis #(
    parameter int CELLS = pbsr_pkg::GRID_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              a_en,
    input  wire logic                              b_en,
    input  wire logic [pbsr_pkg::POS_W-1:0]        pos,
    input  wire logic signed [pbsr_pkg::VEL_W-1:0] vel,
    input  wire logic [pbsr_pkg::MARGIN_W-1:0]     margin,
    input  wire logic [pbsr_pkg::DAMP_W-1:0]       damping,
    output logic [pbsr_pkg::POS_W-1:0]             pos_new,
    output logic signed [pbsr_pkg::VEL_W-1:0]      vel_new
);
    import pbsr_pkg::*;

    localparam logic signed [SUM_W-1:0] SIZE = SUM_W'(CELLS * 256);

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [VEL_W-1:0] vel_a_reg;
    logic signed [SUM_W-1:0] sum_next;

    logic signed [SUM_W-1:0] m_s;
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] p_hi;
    logic signed [SUM_W-1:0] p_clamp;
    logic                    bounce;
    logic                    neg;
    logic [VEL_W-1:0]        mag;

    logic [POS_W-1:0]        pos_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    bounce_reg;
    logic                    neg_reg;
    logic signed [VEL_W-1:0] vel_b_reg;

    logic [MAG_W-1:0]        scaled;
    logic signed [VEL_W-1:0] vel_bounce;

    assign sum_next = $signed(SUM_W'(pos)) + SUM_W'(vel);

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            sum_reg   <= sum_next;
            vel_a_reg <= vel;
        end
    end

    // Border test, clamp and velocity magnitude for the damping product
    always_comb
    begin
        m_s     = $signed(SUM_W'(margin));
        lim     = SIZE - m_s;
        hi      = lim - INSET_LSB;
        bounce  = (sum_reg < m_s) || (sum_reg >= lim);
        p_hi    = (sum_reg > hi) ? hi : sum_reg;
        p_clamp = (p_hi < m_s) ? m_s : p_hi;
        neg     = vel_a_reg[VEL_W-1];
        mag     = neg ? (VEL_W'(0) - VEL_W'(vel_a_reg)) : VEL_W'(vel_a_reg);
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            pos_reg    <= bounce ? p_clamp[POS_W-1:0] : sum_reg[POS_W-1:0];
            prod_reg   <= PROD_W'(mag) * PROD_W'(damping);
            bounce_reg <= bounce;
            neg_reg    <= neg;
            vel_b_reg  <= vel_a_reg;
        end
    end

    // Flip the sign and saturate
    always_comb
    begin
        scaled = prod_reg[PROD_W-1:8];
        if (neg_reg)
        begin
            vel_bounce = (scaled > POS_MAG_MAX) ? VEL_MAX : $signed(scaled[VEL_W-1:0]);
        end
        else
        begin
            vel_bounce = (scaled > NEG_MAG_MAX) ? VEL_MIN
                                                : $signed(VEL_W'(MAG_W'(0) - scaled));
        end
    end

    assign vel_new = bounce_reg ? vel_bounce : vel_b_reg;
    assign pos_new = pos_reg;

endmodule

`default_nettype wire

// ===== design/pbsr_datapath.sv =====
`default_nettype none

module pbsr_datapath #(
    parameter int MAX_PARTICLES = pbsr_pkg::MAX_PARTICLES_DEF,
    parameter int GRID_WIDTH    = pbsr_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT   = pbsr_pkg::GRID_HEIGHT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pbsr_pkg::cmd_item_t                 cmd_data,
    input  wire logic                                cfg_we,
    input  wire logic [pbsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pbsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire pbsr_pkg::pbsr_cmd_t                 ctl,
    output pbsr_pkg::pbsr_stat_t                     stat,
    output pbsr_pkg::row_item_t                      row_data
);
    import pbsr_pkg::*;

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int RW = $clog2(GRID_HEIGHT);

    logic [GRAV_W-1:0]   gravity_reg;
    logic [DAMP_W-1:0]   damping_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [AW-1:0] pidx_reg;
    logic [RW-1:0] row_idx_reg;
    logic [CW-1:0] n_eff;
    logic [NW-1:0] count_w;

    particle_t store_mem [MAX_PARTICLES];
    particle_t store_q_reg;
    logic [AW-1:0] store_raddr;
    logic          store_we;
    logic [AW-1:0] store_waddr;
    particle_t     store_wdata;
    logic [SW-1:0] slot_w;
    logic          slot_ok;
    particle_t     load_item;

    logic signed [VEL_W:0]   vy_sum;
    logic signed [VEL_W-1:0] vy_grav;

    logic [POS_W-1:0]        pos_x_new;
    logic [POS_W-1:0]        pos_y_new;
    logic signed [VEL_W-1:0] vel_x_new;
    logic signed [VEL_W-1:0] vel_y_new;

    logic [CELL_W-1:0] cx_raw;
    logic [CELL_W-1:0] cy_raw;
    logic [CELL_W-1:0] cx_next;
    logic [CELL_W-1:0] cy_clamp;
    logic [RW-1:0]     cy_next;
    logic [CELL_W-1:0] cx_reg;
    logic [RW-1:0]     cy_reg;

    logic [ROW_CELLS_W-1:0] bitmap_mem [GRID_HEIGHT];
    logic [ROW_CELLS_W-1:0] bitmap_q_reg;
    logic                   bm_we;
    logic [RW-1:0]          bm_waddr;
    logic [ROW_CELLS_W-1:0] bm_wdata;
    logic                   bm_re;
    logic [RW-1:0]          bm_raddr;

    row_item_t row_out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= GRAVITY_RESET;
            damping_reg <= DAMPING_RESET;
            margin_reg  <= MARGIN_RESET;
            count_reg   <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRAVITY_STEP:   gravity_reg <= cfg_wdata[GRAV_W-1:0];
                CFG_BOUNCE_DAMPING: damping_reg <= cfg_wdata[DAMP_W-1:0];
                CFG_WALL_MARGIN:    margin_reg  <= cfg_wdata[MARGIN_W-1:0];
                CFG_PARTICLE_COUNT: count_reg   <= cfg_wdata[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pidx_reg    <= '0;
            row_idx_reg <= '0;
        end
        else
        begin
            if (ctl.idx_zero)
                pidx_reg <= '0;
            else if (ctl.idx_inc)
                pidx_reg <= pidx_reg + AW'(1);

            if (ctl.row_zero)
                row_idx_reg <= '0;
            else if (ctl.row_inc)
                row_idx_reg <= row_idx_reg + RW'(1);
        end
    end

    always_comb
    begin
        count_w = NW'(count_reg);
        n_eff   = (count_w > NW'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES) : CW'(count_w);
    end

    assign stat.n_zero   = (n_eff == '0);
    assign stat.idx_last = ((CW'(pidx_reg) + CW'(1)) == n_eff);
    assign stat.row_last = (row_idx_reg == RW'(GRID_HEIGHT - 1));

    // Particle store: one write port, one registered read port
    always_comb
    begin
        slot_w            = SW'(cmd_data.slot);
        slot_ok           = (slot_w < SW'(MAX_PARTICLES));
        load_item.pos_x   = POS_W'(cmd_data.pos_x);
        load_item.pos_y   = POS_W'(cmd_data.pos_y);
        load_item.vel_x   = cmd_data.vel_x;
        load_item.vel_y   = cmd_data.vel_y;

        store_we    = (ctl.load_wr && slot_ok) || ctl.wb_en;
        store_waddr = ctl.wb_en ? pidx_reg : slot_w[AW-1:0];
        if (ctl.wb_en)
        begin
            store_wdata.pos_x = pos_x_new;
            store_wdata.pos_y = pos_y_new;
            store_wdata.vel_x = vel_x_new;
            store_wdata.vel_y = vel_y_new;
        end
        else
        begin
            store_wdata = load_item;
        end
        store_raddr = ctl.rd_next ? (pidx_reg + AW'(1)) : pidx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_waddr] <= store_wdata;
        if (ctl.store_rd)
            store_q_reg <= store_mem[store_raddr];
    end

    // Gravity, saturated at the top only
    always_comb
    begin
        vy_sum  = $signed({store_q_reg.vel_y[VEL_W-1], store_q_reg.vel_y})
                + $signed({5'b00000, gravity_reg});
        vy_grav = (vy_sum > VEL_MAX_W) ? VEL_MAX : vy_sum[VEL_W-1:0];
    end

    pbsr_axis #(
        .CELLS (GRID_WIDTH)
    ) u_axis_x (
        .clk     (clk),
        .a_en    (ctl.a_en),
        .b_en    (ctl.b_en),
        .pos     (store_q_reg.pos_x),
        .vel     (store_q_reg.vel_x),
        .margin  (margin_reg),
        .damping (damping_reg),
        .pos_new (pos_x_new),
        .vel_new (vel_x_new)
    );

    pbsr_axis #(
        .CELLS (GRID_HEIGHT)
    ) u_axis_y (
        .clk     (clk),
        .a_en    (ctl.a_en),
        .b_en    (ctl.b_en),
        .pos     (store_q_reg.pos_y),
        .vel     (vy_grav),
        .margin  (margin_reg),
        .damping (damping_reg),
        .pos_new (pos_y_new),
        .vel_new (vel_y_new)
    );

    // Cell of the updated particle, clamped to the grid
    always_comb
    begin
        cx_raw   = pos_x_new[POS_W-1:8];
        cy_raw   = pos_y_new[POS_W-1:8];
        cx_next  = (cx_raw > CELL_W'(GRID_WIDTH - 1)) ? CELL_W'(GRID_WIDTH - 1) : cx_raw;
        cy_clamp = (cy_raw > CELL_W'(GRID_HEIGHT - 1)) ? CELL_W'(GRID_HEIGHT - 1) : cy_raw;
        cy_next  = RW'(cy_clamp);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wb_en)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    // Frame bitmap: clear sweep, read-modify-write plot, row readout
    always_comb
    begin
        bm_we    = ctl.clr_wr || ctl.plot_wr;
        bm_waddr = ctl.clr_wr ? row_idx_reg : cy_reg;
        bm_wdata = ctl.clr_wr ? '0
                              : (bitmap_q_reg | (ROW_CELLS_W'(1) << cx_reg));
        bm_re    = ctl.wb_en || ctl.emit_rd;
        if (ctl.wb_en)
            bm_raddr = cy_next;
        else if (ctl.emit_next)
            bm_raddr = row_idx_reg + RW'(1);
        else
            bm_raddr = row_idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (bm_we)
            bitmap_mem[bm_waddr] <= bm_wdata;
        if (bm_re)
            bitmap_q_reg <= bitmap_mem[bm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            row_out_reg.row_number <= ROW_NUM_W'(row_idx_reg);
            row_out_reg.row_cells  <= bitmap_q_reg;
            row_out_reg.final_row  <= stat.row_last;
        end
    end

    assign row_data = row_out_reg;

endmodule

`default_nettype wire

// ===== design/pbsr_ctrl.sv =====
`default_nettype none

module pbsr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    input  wire logic                 cmd_op,
    input  wire logic                 row_ready,
    input  wire pbsr_pkg::pbsr_stat_t stat,
    output logic                      cmd_ready,
    output logic                      row_valid,
    output pbsr_pkg::pbsr_cmd_t       ctl
);
    import pbsr_pkg::*;

    pbsr_state_t state_reg;
    pbsr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd_op == OP_TICK))
                    state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (stat.row_last)
                    state_next = stat.n_zero ? ST_EMIT_READ : ST_READ;
            end
            ST_READ:    state_next = ST_STAGE_A;
            ST_STAGE_A: state_next = ST_STAGE_B;
            ST_STAGE_B: state_next = ST_WRITE;
            ST_WRITE:   state_next = ST_PLOT;
            ST_PLOT:
            begin
                state_next = stat.idx_last ? ST_EMIT_READ : ST_STAGE_A;
            end
            ST_EMIT_READ: state_next = ST_EMIT_LOAD;
            ST_EMIT_LOAD: state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (row_ready)
                    state_next = stat.row_last ? ST_IDLE : ST_EMIT_LOAD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl       = '0;
        cmd_ready = 1'b0;
        row_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd_op == OP_TICK)
                    begin
                        ctl.row_zero = 1'b1;
                        ctl.idx_zero = 1'b1;
                    end
                    else
                    begin
                        ctl.load_wr = 1'b1;
                    end
                end
            end
            ST_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (stat.row_last)
                    ctl.row_zero = 1'b1;
                else
                    ctl.row_inc = 1'b1;
            end
            ST_READ:    ctl.store_rd = 1'b1;
            ST_STAGE_A: ctl.a_en = 1'b1;
            ST_STAGE_B: ctl.b_en = 1'b1;
            ST_WRITE:   ctl.wb_en = 1'b1;
            ST_PLOT:
            begin
                ctl.plot_wr = 1'b1;
                // fetch the next particle while this one is plotted
                if (!stat.idx_last)
                begin
                    ctl.idx_inc  = 1'b1;
                    ctl.store_rd = 1'b1;
                    ctl.rd_next  = 1'b1;
                end
            end
            ST_EMIT_READ: ctl.emit_rd = 1'b1;
            ST_EMIT_LOAD: ctl.out_load = 1'b1;
            ST_EMIT_WAIT:
            begin
                row_valid = 1'b1;
                if (row_ready)
                begin
                    if (stat.row_last)
                    begin
                        ctl.row_zero = 1'b1;
                    end
                    else
                    begin
                        ctl.row_inc   = 1'b1;
                        ctl.emit_rd   = 1'b1;
                        ctl.emit_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/particle_bounce_step_and_raster_unit.sv =====
// Channel   Dir  Handshake              Payload
// cmd       in   cmd_valid / cmd_ready  pbsr_pkg::cmd_item_t (load or tick)
// row       out  row_valid / row_ready  pbsr_pkg::row_item_t (one bitmap row)
// cfg       in   cfg_we                 cfg_index, cfg_wdata
//
// A load with a slot below MAX_PARTICLES is written straight into the particle store.
// A tick steps through: accept, a clear sweep of the bitmap, one store read (skipped with no
// active particles), then per particle stage A, stage B, write-back and plot through the store
// and the bitmap read-modify-write, then one bitmap read and a load and a wait per row.
// Reset clears control and sets configuration to its defaults only; the store is undefined until loaded.
// A stalled row holds in the output register; no new cmd is taken until the frame is out.
`default_nettype none

module particle_bounce_step_and_raster_unit #(
    parameter int MAX_PARTICLES = pbsr_pkg::MAX_PARTICLES_DEF,
    parameter int GRID_WIDTH    = pbsr_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT   = pbsr_pkg::GRID_HEIGHT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire pbsr_pkg::cmd_item_t             cmd_data,
    output logic                                 row_valid,
    input  wire logic                            row_ready,
    output pbsr_pkg::row_item_t                  row_data,
    input  wire logic                            cfg_we,
    input  wire logic [pbsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pbsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pbsr_pkg::*;

    pbsr_cmd_t  ctl;
    pbsr_stat_t stat;

    pbsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_op    (cmd_data.op),
        .row_ready (row_ready),
        .stat      (stat),
        .cmd_ready (cmd_ready),
        .row_valid (row_valid),
        .ctl       (ctl)
    );

    pbsr_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .GRID_WIDTH    (GRID_WIDTH),
        .GRID_HEIGHT   (GRID_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .stat      (stat),
        .row_data  (row_data)
    );

endmodule

`default_nettype wire
